// ===== design/overwrite_oldest_message_ring_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the overwrite-oldest message ring.
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ---------------------------------------------------------------------------
`ifndef OVERWRITE_OLDEST_MESSAGE_RING_MACROS_SVH
`define OVERWRITE_OLDEST_MESSAGE_RING_MACROS_SVH

`ifndef SYNTHESIS

`define OOMR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("overwrite_oldest_message_ring: assertion failed");

`define OOMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("overwrite_oldest_message_ring: assertion failed");

`else

`define OOMR_ASSERT_NOW(label, clk, rst, ante, cons)

`define OOMR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/oomr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oomr_pkg
// Types and codes shared by the controller and the datapath of the ring.
// ---------------------------------------------------------------------------
package oomr_pkg;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_DROP = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DROPPED  = 2'd1;
   localparam logic [1:0] STAT_TOO_LONG = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_BURST
   } state_type;

   typedef struct packed {
      logic push;
      logic read_start;
      logic read_empty;
      logic drop;
      logic burst;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic burst_last;
   } stat_type;

endpackage

// ===== design/oomr_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oomr_ctrl
// Controller: decodes accepted requests and sequences the read burst.
// ---------------------------------------------------------------------------
module oomr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_mode,
   input  oomr_pkg::stat_type stat,
   output logic              busy,
   output oomr_pkg::cmd_type cmd
);
   import oomr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_PUSH: begin
                     cmd.push = 1'b1;
                  end
                  MODE_READ: begin
                     if (stat.empty) begin
                        cmd.read_empty = 1'b1;
                     end else begin
                        cmd.read_start = 1'b1;
                        state_in       = ST_BURST;
                     end
                  end
                  MODE_DROP: begin
                     cmd.drop = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BURST: begin
            busy      = 1'b1;
            cmd.burst = 1'b1;
            if (stat.burst_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/oomr_dp.sv =====
`timescale 1ns / 1ps
`include "overwrite_oldest_message_ring_macros.svh"
// ---------------------------------------------------------------------------
// oomr_dp
// Datapath: byte store, slot lengths, ring pointers and the result registers.
// ---------------------------------------------------------------------------
module oomr_dp #(
   parameter int SLOTS      = 16,
   parameter int SLOT_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  oomr_pkg::cmd_type                 cmd,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   output oomr_pkg::stat_type                stat,
   output logic                              rsp_strobe,
   output logic                              rsp_kind,
   output logic [1:0]                        rsp_status,
   output logic [7:0]                        rsp_out_byte,
   output logic [$clog2(SLOT_BYTES+1)-1:0]   rsp_msg_length,
   output logic                              rsp_last_of_run,
   output logic [$clog2(SLOTS+1)-1:0]        rsp_stored_count
);
   import oomr_pkg::*;

   localparam int PHYS  = SLOTS + 1;
   localparam int SW    = $clog2(SLOTS + 1);
   localparam int OW    = $clog2(SLOT_BYTES + 1);
   localparam int DEPTH = PHYS * SLOT_BYTES;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [SW:0]   PHYS_C  = (SW+1)'(PHYS);
   localparam logic [SW-1:0] SLOTS_C = SW'(SLOTS);
   localparam logic [OW-1:0] SB_O    = OW'(SLOT_BYTES);
   localparam logic [AW-1:0] SB_A    = AW'(SLOT_BYTES);

   logic [7:0]    byte_store  [DEPTH];
   logic [OW-1:0] slot_length [PHYS];

   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] count_ff, count_in;
   logic [OW-1:0] woff_ff, woff_in;
   logic          overlong_ff, overlong_in;
   logic          sres_valid_ff, sres_valid_in;
   logic [1:0]    sres_status_ff, sres_status_in;
   logic [OW-1:0] idx_ff, idx_in;
   logic [OW-1:0] len_ff;
   logic [7:0]    rd_byte_ff;

   logic [SW:0]   stage_sum;
   logic [SW:0]   head_sum;
   logic [SW-1:0] stage_slot;
   logic [SW-1:0] head_next;
   logic [AW-1:0] head_base;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [OW-1:0] woff_plus;
   logic [OW-1:0] idx_plus;
   logic          over_now;
   logic          mem_we;
   logic          mem_re;
   logic          len_we;

   assign stage_sum  = {1'b0, head_ff} + {1'b0, count_ff};
   assign stage_slot = (stage_sum >= PHYS_C) ? SW'(stage_sum - PHYS_C) : SW'(stage_sum);
   assign head_sum   = {1'b0, head_ff} + (SW+1)'(1);
   assign head_next  = (head_sum >= PHYS_C) ? SW'(head_sum - PHYS_C) : SW'(head_sum);
   assign head_base  = AW'(head_ff) * SB_A;
   assign wr_addr    = AW'(stage_slot) * SB_A + AW'(woff_ff);
   assign woff_plus  = woff_ff + OW'(1);
   assign idx_plus   = idx_ff + OW'(1);

   assign stat.empty      = (count_ff == '0);
   assign stat.burst_last = (idx_plus == len_ff);

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      woff_in        = woff_ff;
      overlong_in    = overlong_ff;
      sres_valid_in  = 1'b0;
      sres_status_in = sres_status_ff;
      idx_in         = idx_ff;
      over_now       = overlong_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      len_we         = 1'b0;
      rd_addr        = head_base;

      if (cmd.push) begin
         if (!overlong_ff) begin
            if (woff_ff == SB_O) begin
               over_now = 1'b1;
            end else begin
               mem_we  = 1'b1;
               woff_in = woff_plus;
            end
         end
         if (req_last_byte) begin
            sres_valid_in = 1'b1;
            woff_in       = '0;
            overlong_in   = 1'b0;
            if (over_now) begin
               sres_status_in = STAT_TOO_LONG;
            end else begin
               len_we = 1'b1;
               if (count_ff == SLOTS_C) begin
                  head_in        = head_next;
                  sres_status_in = STAT_DROPPED;
               end else begin
                  count_in       = count_ff + SW'(1);
                  sres_status_in = STAT_OK;
               end
            end
         end else begin
            overlong_in = over_now;
         end
      end

      if (cmd.read_empty) begin
         sres_valid_in  = 1'b1;
         sres_status_in = STAT_EMPTY;
      end

      if (cmd.read_start) begin
         mem_re = 1'b1;
         idx_in = '0;
      end

      if (cmd.drop) begin
         sres_valid_in = 1'b1;
         if (count_ff == '0) begin
            sres_status_in = STAT_EMPTY;
         end else begin
            sres_status_in = STAT_OK;
            head_in        = head_next;
            count_in       = count_ff - SW'(1);
         end
      end

      if (cmd.burst && !stat.burst_last) begin
         mem_re  = 1'b1;
         rd_addr = head_base + AW'(idx_plus);
         idx_in  = idx_plus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         woff_ff       <= '0;
         overlong_ff   <= 1'b0;
         sres_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         woff_ff       <= woff_in;
         overlong_ff   <= overlong_in;
         sres_valid_ff <= sres_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sres_status_ff <= sres_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_store[wr_addr] <= req_data_byte;
      end
      if (mem_re) begin
         rd_byte_ff <= byte_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         slot_length[stage_slot] <= woff_plus;
      end
      if (cmd.read_start) begin
         len_ff <= slot_length[head_ff];
      end
   end

   assign rsp_strobe       = sres_valid_ff | cmd.burst;
   assign rsp_kind         = cmd.burst ? KIND_DATA : KIND_STATUS;
   assign rsp_status       = cmd.burst ? STAT_OK : sres_status_ff;
   assign rsp_out_byte     = cmd.burst ? rd_byte_ff : 8'd0;
   assign rsp_msg_length   = cmd.burst ? len_ff : '0;
   assign rsp_last_of_run  = cmd.burst ? stat.burst_last : 1'b1;
   assign rsp_stored_count = count_ff;

   `OOMR_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= SLOTS_C)
   `OOMR_ASSERT_NOW(a_woff_range, clock, reset, 1'b1, woff_ff <= SB_O)
   `OOMR_ASSERT_NOW(a_burst_alone, clock, reset, cmd.burst, !sres_valid_ff && len_ff != '0)
   `OOMR_ASSERT_NEXT(a_burst_holds_ring, clock, reset, cmd.burst, $stable(count_ff) && $stable(head_ff))

endmodule

// ===== design/overwrite_oldest_message_ring.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// overwrite_oldest_message_ring
// Ring of SLOTS byte messages that drops the oldest message when full.
// ---------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low, and its
// results appear from the following cycle, one per cycle, each marked by
// rsp_strobe for a single cycle; the receiver cannot hold them off, so it must
// take every strobed result. Push and drop requests leave busy low and may
// follow one another in every cycle. A read of a non-empty ring holds busy
// high while the bytes of the head message come out, one byte per cycle
// from the single read port of the byte store, and the next request can be
// taken in the cycle after the last byte. Stores are not cleared after reset,
// so the block is ready at once.
module overwrite_oldest_message_ring #(
   parameter int SLOTS      = 16,
   parameter int SLOT_BYTES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_strobe,
   output logic                            rsp_kind,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_out_byte,
   output logic [$clog2(SLOT_BYTES+1)-1:0] rsp_msg_length,
   output logic                            rsp_last_of_run,
   output logic [$clog2(SLOTS+1)-1:0]      rsp_stored_count
);
   import oomr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   oomr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   oomr_dp #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_msg_length   (rsp_msg_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_stored_count (rsp_stored_count)
   );

endmodule

// ===== tb/overwrite_oldest_message_ring_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// overwrite_oldest_message_ring_test
// Drives message pushes, head reads and head drops into the ring, predicts
// status and data results from a model of the ring kept here or, for typed
// directed rows, from the table, and compares each strobed result with the
// oldest prediction. A table of directed requests comes first, followed by
// random traffic built mostly from well-formed messages.
// ---------------------------------------------------------------------------
module overwrite_oldest_message_ring_test;
   import oomr_pkg::*;

   localparam int SLOTS       = 16;
   localparam int SLOT_BYTES  = 64;
   localparam int LEN_W       = $clog2(SLOT_BYTES + 1);
   localparam int COUNT_W     = $clog2(SLOTS + 1);
   localparam int ITEM_TARGET = 430;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic               kind;
      logic [1:0]         status;
      logic [7:0]         out_byte;
      logic [LEN_W-1:0]   msg_length;
      logic               last_of_run;
      logic [COUNT_W-1:0] stored_count;
   } ring_result_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         data;
      logic               last;
      logic [6:0]         nbytes;
      logic [4:0]         nmsgs;
      logic               typed;
      logic [1:0]         t_status;
      logic [COUNT_W-1:0] t_count;
   } stim_row_type;

   localparam int NUM_ROWS = 24;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{MODE_READ,   8'h00, 1'b0,  7'd1,  5'd1, 1'b1, STAT_EMPTY,    5'd0},
      '{MODE_DROP,   8'h00, 1'b0,  7'd1,  5'd1, 1'b1, STAT_EMPTY,    5'd0},
      '{MODE_UNUSED, 8'hFF, 1'b1,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_PUSH,   8'h00, 1'b1,  7'd1,  5'd1, 1'b1, STAT_OK,       5'd1},
      '{MODE_PUSH,   8'hFF, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_PUSH,   8'hA5, 1'b1,  7'd1,  5'd1, 1'b1, STAT_OK,       5'd2},
      '{MODE_READ,   8'h00, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_DROP,   8'h00, 1'b0,  7'd1,  5'd1, 1'b1, STAT_OK,       5'd1},
      '{MODE_READ,   8'h00, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_PUSH,   8'h5A, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_READ,   8'h00, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_DROP,   8'h00, 1'b0,  7'd1,  5'd1, 1'b1, STAT_OK,       5'd0},
      '{MODE_PUSH,   8'h3C, 1'b1,  7'd1,  5'd1, 1'b1, STAT_OK,       5'd1},
      '{MODE_PUSH,   8'h80, 1'b1,  7'd64, 5'd1, 1'b1, STAT_OK,       5'd2},
      '{MODE_PUSH,   8'h00, 1'b1,  7'd65, 5'd1, 1'b1, STAT_TOO_LONG, 5'd2},
      '{MODE_PUSH,   8'h10, 1'b1,  7'd1,  5'd14, 1'b0, STAT_OK,      5'd0},
      '{MODE_PUSH,   8'hC0, 1'b1,  7'd3,  5'd1, 1'b1, STAT_DROPPED,  5'd16},
      '{MODE_READ,   8'h00, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_PUSH,   8'h01, 1'b0,  7'd70, 5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_READ,   8'h00, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_DROP,   8'h00, 1'b0,  7'd1,  5'd1, 1'b1, STAT_OK,       5'd15},
      '{MODE_PUSH,   8'hFF, 1'b1,  7'd1,  5'd1, 1'b1, STAT_TOO_LONG, 5'd15},
      '{MODE_UNUSED, 8'h00, 1'b0,  7'd1,  5'd1, 1'b0, STAT_OK,       5'd0},
      '{MODE_PUSH,   8'h01, 1'b1,  7'd1,  5'd1, 1'b1, STAT_OK,       5'd16}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_mode;
   logic [7:0]         req_data_byte;
   logic               req_last_byte;
   logic               rsp_strobe;
   logic               rsp_kind;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_out_byte;
   logic [LEN_W-1:0]   rsp_msg_length;
   logic               rsp_last_of_run;
   logic [COUNT_W-1:0] rsp_stored_count;

   logic [7:0]  ring_bytes [SLOTS+1][SLOT_BYTES];
   int unsigned ring_len [SLOTS+1];
   int unsigned ring_head;
   int unsigned ring_count;
   int unsigned staged_bytes;
   bit          staging_overlong;

   ring_result_type step_results[$];
   ring_result_type awaited_results[$];
   int          error_count;
   int          cycle_count;
   int          counted_items;
   bit          idling_on;

   overwrite_oldest_message_ring #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_msg_length   (rsp_msg_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_stored_count (rsp_stored_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void add_result(logic kind, logic [1:0] status, logic [7:0] value,
                                      int unsigned len, logic last);
      ring_result_type r;
      r.kind         = kind;
      r.status       = status;
      r.out_byte     = value;
      r.msg_length   = LEN_W'(len);
      r.last_of_run  = last;
      r.stored_count = COUNT_W'(ring_count);
      step_results.push_back(r);
   endfunction

   function automatic void advance_ring(logic [1:0] mode, logic [7:0] value, logic last);
      int unsigned stage;
      int unsigned len;
      step_results.delete();
      case (mode)
         MODE_PUSH: begin
            stage = (ring_head + ring_count) % (SLOTS + 1);
            if (!staging_overlong) begin
               if (staged_bytes >= SLOT_BYTES) begin
                  staging_overlong = 1'b1;
               end else begin
                  ring_bytes[stage][staged_bytes] = value;
                  staged_bytes++;
               end
            end
            if (last) begin
               if (staging_overlong) begin
                  staging_overlong = 1'b0;
                  staged_bytes = 0;
                  add_result(KIND_STATUS, STAT_TOO_LONG, 8'd0, 0, 1'b1);
               end else begin
                  ring_len[stage] = staged_bytes;
                  staged_bytes = 0;
                  if (ring_count >= SLOTS) begin
                     ring_head = (ring_head + 1) % (SLOTS + 1);
                     add_result(KIND_STATUS, STAT_DROPPED, 8'd0, 0, 1'b1);
                  end else begin
                     ring_count++;
                     add_result(KIND_STATUS, STAT_OK, 8'd0, 0, 1'b1);
                  end
               end
            end
         end
         MODE_READ: begin
            if (ring_count == 0) begin
               add_result(KIND_STATUS, STAT_EMPTY, 8'd0, 0, 1'b1);
            end else begin
               len = ring_len[ring_head];
               for (int i = 0; i < len; i++) begin
                  add_result(KIND_DATA, STAT_OK, ring_bytes[ring_head][i], len,
                             i + 1 == len);
               end
            end
         end
         MODE_DROP: begin
            if (ring_count == 0) begin
               add_result(KIND_STATUS, STAT_EMPTY, 8'd0, 0, 1'b1);
            end else begin
               ring_head = (ring_head + 1) % (SLOTS + 1);
               ring_count--;
               add_result(KIND_STATUS, STAT_OK, 8'd0, 0, 1'b1);
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_request(logic [1:0] mode, logic [7:0] value, logic last, bit typed,
                               logic [1:0] t_status, logic [COUNT_W-1:0] t_count);
      ring_result_type r;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start         <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      advance_ring(mode, value, last);
      if (typed) begin
         r.kind         = KIND_STATUS;
         r.status       = t_status;
         r.out_byte     = 8'd0;
         r.msg_length   = '0;
         r.last_of_run  = 1'b1;
         r.stored_count = t_count;
         awaited_results.push_back(r);
      end else begin
         foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      end
      if (mode != MODE_UNUSED) begin
         counted_items++;
      end
   endtask

   task automatic send_random_message();
      int unsigned len;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
         len = $urandom_range(1, 6);
      end else if (pick < 19) begin
         len = $urandom_range(7, SLOT_BYTES);
      end else begin
         len = $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 4);
      end
      for (int b = 0; b < len; b++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_request($urandom_range(0, 1) ? MODE_READ : MODE_DROP,
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                         STAT_OK, '0);
         end
         send_request(MODE_PUSH, 8'($urandom_range(0, 255)), b == len - 1, 1'b0,
                      STAT_OK, '0);
      end
   endtask

   task automatic check_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      ring_result_type e;
      if (!reset && rsp_strobe) begin
         if (awaited_results.size() == 0) begin
            $error("result strobed with none awaited");
            error_count++;
         end else begin
            e = awaited_results.pop_front();
            check_field("kind", e.kind, rsp_kind);
            check_field("status", e.status, rsp_status);
            check_field("out_byte", e.out_byte, rsp_out_byte);
            check_field("msg_length", e.msg_length, rsp_msg_length);
            check_field("last_of_run", e.last_of_run, rsp_last_of_run);
            check_field("stored_count", e.stored_count, rsp_stored_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int unsigned pick;
      int unsigned nb;
      error_count      = 0;
      cycle_count      = 0;
      counted_items    = 0;
      idling_on        = 1'b0;
      ring_head        = 0;
      ring_count       = 0;
      staged_bytes     = 0;
      staging_overlong = 1'b0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_mode      <= MODE_PUSH;
      req_data_byte <= 8'd0;
      req_last_byte <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         row = DIRECTED_ROWS[r];
         for (int m = 0; m < row.nmsgs; m++) begin
            nb = row.nbytes;
            for (int b = 0; b < nb; b++) begin
               send_request(row.mode, row.data + 8'(b + m),
                            (b == nb - 1) ? row.last : 1'b0,
                            row.typed && b == nb - 1, row.t_status, row.t_count);
            end
         end
      end

      while (counted_items < ITEM_TARGET) begin
         idling_on = counted_items < ITEM_TARGET - 60;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_random_message();
         end else if (pick < 75) begin
            send_request(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'b0, STAT_OK, '0);
         end else if (pick < 93) begin
            send_request(MODE_DROP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'b0, STAT_OK, '0);
         end else begin
            send_request(MODE_UNUSED, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'b0, STAT_OK, '0);
         end
      end

      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
